[src/biquad_eq_cascade_assert.svh]
// assertion macros used by the checker of the equalizer
`ifndef BIQUAD_EQ_CASCADE_ASSERT_SVH
`define BIQUAD_EQ_CASCADE_ASSERT_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define BEQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, quiet during reset
`define BEQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/beq_pkg.sv]
// shared constants, codes and controller/datapath interface types
`timescale 1ns / 1ps

package beq_pkg;

    // default sizes
    localparam int SECTIONS_DEF       = 4;
    localparam int SAMPLE_BITS_DEF    = 24;
    localparam int COEF_FRAC_BITS_DEF = 27;

    // fixed field and arithmetic widths
    localparam int COEFS_PER_SECTION = 5;
    localparam int SIGNAL_BITS       = 32;
    localparam int STATE_BITS        = 40;
    localparam int COEF_BITS         = 32;
    localparam int ENABLE_BITS       = 4;
    localparam int SEL_W             = 2;
    localparam int COEF_IDX_W        = 3;
    localparam int CFG_DATA_W        = 32;
    localparam int CFG_ADDR_W        = 3;

    // operation codes carried in tuser
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_COEF   = 1'b1;

    // register index of section_enable (paddr word bit)
    localparam logic REG_SECTION_ENABLE = 1'b0;

    // coefficient slots within one section
    localparam logic [COEF_IDX_W-1:0] COEF_B0 = 3'd0;
    localparam logic [COEF_IDX_W-1:0] COEF_B1 = 3'd1;
    localparam logic [COEF_IDX_W-1:0] COEF_B2 = 3'd2;
    localparam logic [COEF_IDX_W-1:0] COEF_A1 = 3'd3;
    localparam logic [COEF_IDX_W-1:0] COEF_A2 = 3'd4;

    // accumulate operations of the datapath
    typedef enum logic [2:0] {
        ACC_NONE,
        ACC_Y,
        ACC_B1,
        ACC_B2,
        ACC_A1,
        ACC_A2
    } acc_op_t;

    // commands from the controller
    typedef struct packed {
        logic                  load;
        logic                  coef_wr;
        logic                  rd_en;
        logic [COEF_IDX_W-1:0] rd_idx;
        logic                  mul_en;
        logic                  mul_sel_y;
        acc_op_t               acc_op;
        logic                  finish;
    } beq_cmd_t;

    // status back to the controller
    typedef struct packed {
        logic out_full;
    } beq_stat_t;

endpackage

[src/beq_ram.sv]
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module beq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 20,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[src/beq_ctrl.sv]
// sequencer: walks the sections and, for each enabled one, the steps over its five coefficients
`timescale 1ns / 1ps

module beq_ctrl #(
    parameter int SECTIONS = beq_pkg::SECTIONS_DEF,
    localparam int SEC_W = (SECTIONS > 1) ? $clog2(SECTIONS) : 1
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    input  logic                             s_tuser,
    output logic                             s_tready,
    input  logic [beq_pkg::ENABLE_BITS-1:0]  section_enable,
    input  beq_pkg::beq_stat_t               stat,
    output beq_pkg::beq_cmd_t                cmd,
    output logic [SEC_W-1:0]                 sec
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RUN,
        ST_FINISH
    } state_t;

    localparam logic [2:0] STEP_LAST = 3'd6;

    state_t           state_reg, state_next;
    logic [SEC_W-1:0] sec_reg, sec_next;
    logic [2:0]       step_reg, step_next;
    logic             sec_on;
    logic             sec_last;

    // enable bit of the current section, sections past the register stay off
    always_comb
    begin
        sec_on = 1'b0;
        for (int i = 0; i < beq_pkg::ENABLE_BITS; i++)
        begin
            if (i < SECTIONS && sec_reg == SEC_W'(i))
            begin
                sec_on = section_enable[i];
            end
        end
    end

    assign sec_last = (sec_reg == SEC_W'(SECTIONS - 1));

    // next state and commands
    always_comb
    begin
        state_next  = state_reg;
        sec_next    = sec_reg;
        step_next   = step_reg;
        cmd         = '0;
        cmd.acc_op  = beq_pkg::ACC_NONE;
        s_tready    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    if (s_tuser == beq_pkg::OP_COEF)
                    begin
                        cmd.coef_wr = 1'b1;
                    end
                    else
                    begin
                        cmd.load   = 1'b1;
                        sec_next   = '0;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (sec_on)
                begin
                    step_next  = '0;
                    state_next = ST_RUN;
                end
                else if (sec_last)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    sec_next = sec_reg + SEC_W'(1);
                end
            end
            ST_RUN:
            begin
                step_next = step_reg + 3'd1;
                // read, multiply and accumulate overlap through the ram and product registers
                case (step_reg)
                    3'd0:
                    begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_idx = beq_pkg::COEF_B0;
                    end
                    3'd1:
                    begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_idx = beq_pkg::COEF_B1;
                        cmd.mul_en = 1'b1;
                    end
                    3'd2:
                    begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_idx = beq_pkg::COEF_B2;
                        cmd.mul_en = 1'b1;
                        cmd.acc_op = beq_pkg::ACC_Y;
                    end
                    3'd3:
                    begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_idx = beq_pkg::COEF_A1;
                        cmd.mul_en = 1'b1;
                        cmd.acc_op = beq_pkg::ACC_B1;
                    end
                    3'd4:
                    begin
                        cmd.rd_en     = 1'b1;
                        cmd.rd_idx    = beq_pkg::COEF_A2;
                        cmd.mul_en    = 1'b1;
                        cmd.mul_sel_y = 1'b1;
                        cmd.acc_op    = beq_pkg::ACC_B2;
                    end
                    3'd5:
                    begin
                        cmd.mul_en    = 1'b1;
                        cmd.mul_sel_y = 1'b1;
                        cmd.acc_op    = beq_pkg::ACC_A1;
                    end
                    3'd6:
                    begin
                        cmd.acc_op = beq_pkg::ACC_A2;
                    end
                    default:
                    begin
                        cmd.acc_op = beq_pkg::ACC_NONE;
                    end
                endcase
                if (step_reg == STEP_LAST)
                begin
                    if (sec_last)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        sec_next   = sec_reg + SEC_W'(1);
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_FINISH:
            begin
                if (!stat.out_full)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            sec_reg   <= '0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sec_reg   <= sec_next;
            step_reg  <= step_next;
        end
    end

    assign sec = sec_reg;

endmodule

[src/beq_datapath.sv]
// coefficient store, shared multiplier, accumulator, delay states and output register
`timescale 1ns / 1ps

module beq_datapath #(
    parameter int SECTIONS       = beq_pkg::SECTIONS_DEF,
    parameter int SAMPLE_BITS    = beq_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_FRAC_BITS = beq_pkg::COEF_FRAC_BITS_DEF,
    localparam int SEC_W = (SECTIONS > 1) ? $clog2(SECTIONS) : 1
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  beq_pkg::beq_cmd_t                       cmd,
    input  logic [SEC_W-1:0]                        sec,
    input  logic [SAMPLE_BITS-1:0]                  sample_in,
    input  logic [beq_pkg::SEL_W-1:0]               section_select,
    input  logic [beq_pkg::COEF_IDX_W-1:0]          coef_index,
    input  logic [beq_pkg::COEF_BITS-1:0]           coef_value,
    input  logic                                    block_end,
    input  logic                                    m_tready,
    output logic                                    m_tvalid,
    output logic [SAMPLE_BITS-1:0]                  sample_out,
    output logic                                    clipped,
    output logic                                    block_end_out,
    output beq_pkg::beq_stat_t                      stat
);

    localparam int SIG_W  = beq_pkg::SIGNAL_BITS;
    localparam int ST_W   = beq_pkg::STATE_BITS;
    localparam int CB_W   = beq_pkg::COEF_BITS;
    localparam int PROD_W = CB_W + SIG_W;
    localparam int RND_W  = PROD_W - COEF_FRAC_BITS;
    localparam int ACC_W  = ((RND_W > ST_W) ? RND_W : ST_W) + 2;
    localparam int CDEPTH = SECTIONS * beq_pkg::COEFS_PER_SECTION;
    localparam int ADDR_W = (CDEPTH > 1) ? $clog2(CDEPTH) : 1;

    localparam logic signed [CB_W-1:0]   COEF_ONE = 32'sd1 <<< COEF_FRAC_BITS;
    localparam logic signed [PROD_W-1:0] HALF     = 64'sd1 <<< (COEF_FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0]  SIG_MAX  = (ACC_W'(1) <<< (SIG_W - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0]  SIG_MIN  = -SIG_MAX - ACC_W'(1);
    localparam logic signed [ACC_W-1:0]  ST_MAX   = (ACC_W'(1) <<< (ST_W - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0]  ST_MIN   = -ST_MAX - ACC_W'(1);
    localparam logic signed [SIG_W-1:0]  OUT_MAX  = (32'sd1 <<< (SAMPLE_BITS - 1)) - 32'sd1;
    localparam logic signed [SIG_W-1:0]  OUT_MIN  = -OUT_MAX - 32'sd1;

    logic [7:0]                wr_lin, rd_lin;
    logic [ADDR_W-1:0]         wr_addr, rd_addr;
    logic                      wr_ok, wr_en;
    logic [CB_W-1:0]           ram_q;
    logic [CDEPTH-1:0]         valid_reg;
    logic                      rd_valid_reg, rd_b0_reg;
    logic signed [CB_W-1:0]    coef;
    logic signed [SIG_W-1:0]   x_reg, y_reg, operand;
    logic signed [PROD_W-1:0]  prod_reg, rnd_full, rnd_shift;
    logic signed [ACC_W-1:0]   rnd_ext, acc_a, sum, t1_reg, t2_reg;
    logic signed [ST_W-1:0]    z1_reg [SECTIONS];
    logic signed [ST_W-1:0]    z2_reg [SECTIONS];
    logic                      acc_sub;
    logic                      sig_hi, sig_lo, st_hi, st_lo, out_hi, out_lo;
    logic signed [SIG_W-1:0]   sig_sat;
    logic signed [ST_W-1:0]    st_sat;
    logic                      flag_reg, last_reg;
    logic                      out_valid_reg;
    logic [SAMPLE_BITS-1:0]    out_data_reg, out_sat;
    logic                      out_clip_reg, out_last_reg;

    // coefficient addressing, out-of-range writes are dropped
    assign wr_ok   = (int'(section_select) < SECTIONS) &&
                     (coef_index < 3'(beq_pkg::COEFS_PER_SECTION));
    assign wr_en   = cmd.coef_wr & wr_ok;
    assign wr_lin  = 8'(section_select) * 8'(beq_pkg::COEFS_PER_SECTION) + 8'(coef_index);
    assign rd_lin  = 8'(sec) * 8'(beq_pkg::COEFS_PER_SECTION) + 8'(cmd.rd_idx);
    assign wr_addr = wr_lin[ADDR_W-1:0];
    assign rd_addr = rd_lin[ADDR_W-1:0];

    beq_ram #(
        .WIDTH (CB_W),
        .DEPTH (CDEPTH)
    ) u_coef_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (coef_value),
        .re    (cmd.rd_en),
        .raddr (rd_addr),
        .rdata (ram_q)
    );

    // unwritten entries read as their reset value: b0 one, others zero
    always_comb
    begin
        if (rd_valid_reg)
        begin
            coef = signed'(ram_q);
        end
        else if (rd_b0_reg)
        begin
            coef = COEF_ONE;
        end
        else
        begin
            coef = '0;
        end
    end

    assign operand = cmd.mul_sel_y ? y_reg : x_reg;

    // rounding of the registered product, ties toward plus infinity
    assign rnd_full  = prod_reg + HALF;
    assign rnd_shift = rnd_full >>> COEF_FRAC_BITS;
    assign rnd_ext   = ACC_W'(rnd_shift);

    // shared adder operand select
    always_comb
    begin
        acc_a   = '0;
        acc_sub = 1'b0;
        case (cmd.acc_op)
            beq_pkg::ACC_Y:  acc_a = ACC_W'(z1_reg[sec]);
            beq_pkg::ACC_B1: acc_a = ACC_W'(z2_reg[sec]);
            beq_pkg::ACC_B2: acc_a = '0;
            beq_pkg::ACC_A1:
            begin
                acc_a   = t1_reg;
                acc_sub = 1'b1;
            end
            beq_pkg::ACC_A2:
            begin
                acc_a   = t2_reg;
                acc_sub = 1'b1;
            end
            default: acc_a = '0;
        endcase
    end

    assign sum = acc_sub ? (acc_a - rnd_ext) : (acc_a + rnd_ext);

    // saturation to the signal and state widths
    assign sig_hi  = sum > SIG_MAX;
    assign sig_lo  = sum < SIG_MIN;
    assign sig_sat = sig_hi ? SIG_W'(SIG_MAX) : (sig_lo ? SIG_W'(SIG_MIN) : SIG_W'(sum));
    assign st_hi   = sum > ST_MAX;
    assign st_lo   = sum < ST_MIN;
    assign st_sat  = st_hi ? ST_W'(ST_MAX) : (st_lo ? ST_W'(ST_MIN) : ST_W'(sum));

    // final saturation to the sample width
    assign out_hi  = x_reg > OUT_MAX;
    assign out_lo  = x_reg < OUT_MIN;
    assign out_sat = out_hi ? OUT_MAX[SAMPLE_BITS-1:0] :
                     (out_lo ? OUT_MIN[SAMPLE_BITS-1:0] : x_reg[SAMPLE_BITS-1:0]);

    // control and filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < SECTIONS; i++)
            begin
                z1_reg[i] <= '0;
                z2_reg[i] <= '0;
            end
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (cmd.acc_op == beq_pkg::ACC_A1)
            begin
                z1_reg[sec] <= st_sat;
            end
            if (cmd.acc_op == beq_pkg::ACC_A2)
            begin
                z2_reg[sec] <= st_sat;
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rd_valid_reg <= valid_reg[rd_addr];
            rd_b0_reg    <= (cmd.rd_idx == beq_pkg::COEF_B0);
        end
        if (cmd.mul_en)
        begin
            prod_reg <= coef * operand;
        end
        if (cmd.load)
        begin
            x_reg    <= SIG_W'(signed'(sample_in));
            last_reg <= block_end;
            flag_reg <= 1'b0;
        end
        else
        begin
            case (cmd.acc_op)
                beq_pkg::ACC_Y:
                begin
                    y_reg    <= sig_sat;
                    flag_reg <= flag_reg | sig_hi | sig_lo;
                end
                beq_pkg::ACC_B1: t1_reg <= sum;
                beq_pkg::ACC_B2: t2_reg <= sum;
                beq_pkg::ACC_A1: flag_reg <= flag_reg | st_hi | st_lo;
                beq_pkg::ACC_A2:
                begin
                    flag_reg <= flag_reg | st_hi | st_lo;
                    x_reg    <= y_reg;
                end
                default: flag_reg <= flag_reg;
            endcase
        end
        if (cmd.finish)
        begin
            out_data_reg <= out_sat;
            out_clip_reg <= flag_reg | out_hi | out_lo;
            out_last_reg <= last_reg;
        end
    end

    assign m_tvalid      = out_valid_reg;
    assign sample_out    = out_data_reg;
    assign clipped       = out_clip_reg;
    assign block_end_out = out_last_reg;
    assign stat.out_full = out_valid_reg & ~m_tready;

endmodule

[src/biquad_eq_cascade.sv]
// top level of the cascaded biquad equalizer
`timescale 1ns / 1ps

// Cascaded biquad equalizer: SECTIONS transposed direct-form-II sections in
// series, each bypassed unless its section_enable bit is set. A request with
// tuser high writes one Q4.27 coefficient (no result); a request with tuser
// low filters one sample and yields one result. Each sample runs through the
// enabled sections on the one shared 32x32 multiplier, fed from the single
// read port of the coefficient ram: each enabled section works through its
// five products in turn. A new request is taken only once the previous sample
// has reached the output register; a result waiting there does not hold up
// the next request. No clearing pass is needed after reset.
module biquad_eq_cascade #(
    parameter int SECTIONS       = beq_pkg::SECTIONS_DEF,
    parameter int SAMPLE_BITS    = beq_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_FRAC_BITS = beq_pkg::COEF_FRAC_BITS_DEF,
    localparam int IN_W  = ((SAMPLE_BITS + beq_pkg::SEL_W + beq_pkg::COEF_IDX_W
                            + beq_pkg::COEF_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // sample_in, section_select, coef_index, coef_value, zero fill
    input  logic [IN_W-1:0]                   s_tdata,
    // operation
    input  logic                              s_tuser,
    input  logic                              s_tlast,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // sample_out, zero fill
    output logic [OUT_W-1:0]                  m_tdata,
    // clipped
    output logic                              m_tuser,
    output logic                              m_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [beq_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [beq_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [beq_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                              pready
);

    localparam int SEC_W  = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
    localparam int SEL_LO = SAMPLE_BITS;
    localparam int IDX_LO = SEL_LO + beq_pkg::SEL_W;
    localparam int CV_LO  = IDX_LO + beq_pkg::COEF_IDX_W;

    logic [beq_pkg::ENABLE_BITS-1:0]  enable_reg;
    logic                             cfg_wr;
    beq_pkg::beq_cmd_t                cmd;
    beq_pkg::beq_stat_t               stat;
    logic [SEC_W-1:0]                 sec;
    logic [SAMPLE_BITS-1:0]           sample_out;

    // configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready &
                    (paddr[2] == beq_pkg::REG_SECTION_ENABLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= '0;
        end
        else if (cfg_wr)
        begin
            enable_reg <= pwdata[beq_pkg::ENABLE_BITS-1:0];
        end
    end

    assign prdata = (paddr[2] == beq_pkg::REG_SECTION_ENABLE) ?
                    beq_pkg::CFG_DATA_W'(enable_reg) : '0;

    beq_ctrl #(
        .SECTIONS (SECTIONS)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tuser        (s_tuser),
        .s_tready       (s_tready),
        .section_enable (enable_reg),
        .stat           (stat),
        .cmd            (cmd),
        .sec            (sec)
    );

    beq_datapath #(
        .SECTIONS       (SECTIONS),
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sec            (sec),
        .sample_in      (s_tdata[SAMPLE_BITS-1:0]),
        .section_select (s_tdata[IDX_LO-1:SEL_LO]),
        .coef_index     (s_tdata[CV_LO-1:IDX_LO]),
        .coef_value     (s_tdata[CV_LO+beq_pkg::COEF_BITS-1:CV_LO]),
        .block_end      (s_tlast),
        .m_tready       (m_tready),
        .m_tvalid       (m_tvalid),
        .sample_out     (sample_out),
        .clipped        (m_tuser),
        .block_end_out  (m_tlast),
        .stat           (stat)
    );

    assign m_tdata = OUT_W'(sample_out);

endmodule

[src/beq_checker.sv]
// port-level checks of the equalizer and their binding to the top level
`timescale 1ns / 1ps
`include "biquad_eq_cascade_assert.svh"

module beq_checker #(
    parameter int SAMPLE_BITS = beq_pkg::SAMPLE_BITS_DEF,
    localparam int OUT_W = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              s_tuser,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [OUT_W-1:0]                  m_tdata,
    input logic                              psel,
    input logic                              penable,
    input logic                              pwrite,
    input logic [beq_pkg::CFG_ADDR_W-1:0]    paddr,
    input logic [beq_pkg::CFG_DATA_W-1:0]    pwdata,
    input logic [beq_pkg::CFG_DATA_W-1:0]    prdata
);

    // a sample request keeps the block busy for at least the next cycle
    `BEQ_ASSERT_NEXT(a_busy_after_sample, s_tvalid && s_tready && (s_tuser == beq_pkg::OP_SAMPLE), !s_tready, "sample request accepted but block still ready")

    // a coefficient write never creates a result
    `BEQ_ASSERT_NEXT(a_coef_no_result, s_tvalid && s_tready && (s_tuser == beq_pkg::OP_COEF) && !m_tvalid, !m_tvalid, "coefficient write produced a result")

    // a stalled result holds
    `BEQ_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")

    // the enable register reads back what was written
    `BEQ_ASSERT_NEXT(a_cfg_readback, psel && penable && pwrite && (paddr[2] == beq_pkg::REG_SECTION_ENABLE), (paddr[2] != beq_pkg::REG_SECTION_ENABLE) || (prdata[beq_pkg::ENABLE_BITS-1:0] == $past(pwdata[beq_pkg::ENABLE_BITS-1:0])), "section_enable readback mismatch")

endmodule

bind biquad_eq_cascade beq_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_beq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata)
);

[dv/tb_top.sv]
// self-checking testbench of the cascaded biquad equalizer
// with a bit-exact fixed-point predictor
`timescale 1ns / 1ps

module tb_top;

    localparam int     SMP_W         = beq_pkg::SAMPLE_BITS_DEF;
    localparam int     N_SECT        = beq_pkg::SECTIONS_DEF;
    localparam int     FRAC          = beq_pkg::COEF_FRAC_BITS_DEF;
    localparam int     SEL_W         = beq_pkg::SEL_W;
    localparam int     IDX_W         = beq_pkg::COEF_IDX_W;
    localparam int     CV_W          = beq_pkg::COEF_BITS;
    localparam longint COEF_ONE      = longint'(1) << FRAC;
    localparam int     SETTLE_CYCLES = 40;
    localparam int     HOLD_CYCLES   = 300;
    localparam int     STALL_LIMIT   = 3000;
    localparam int     PHASES        = 10;
    localparam int     PHASE_ITEMS   = 95;
    localparam logic [beq_pkg::CFG_ADDR_W-1:0] ENABLE_ADDR =
        {beq_pkg::REG_SECTION_ENABLE, 2'b00};

    typedef struct {
        logic             op;
        logic [SMP_W-1:0] smp;
        logic [SEL_W-1:0] sec;
        logic [IDX_W-1:0] cidx;
        logic [CV_W-1:0]  cval;
        logic             last;
        int               gap;
    } eq_req_t;

    typedef struct {
        logic [SMP_W-1:0] smp;
        logic             clip;
        logic             last;
    } eq_res_t;

    // dut ports
    logic                              clk      = 1'b0;
    logic                              rst_n    = 1'b0;
    logic [63:0]                       s_tdata  = '0;
    logic                              s_tuser  = 1'b0;
    logic                              s_tlast  = 1'b0;
    logic                              s_tvalid = 1'b0;
    logic                              s_tready;
    logic [SMP_W-1:0]                  m_tdata;
    logic                              m_tuser;
    logic                              m_tlast;
    logic                              m_tvalid;
    logic                              m_tready = 1'b0;
    logic                              psel     = 1'b0;
    logic                              penable  = 1'b0;
    logic                              pwrite   = 1'b0;
    logic [beq_pkg::CFG_ADDR_W-1:0]    paddr    = '0;
    logic [beq_pkg::CFG_DATA_W-1:0]    pwdata   = '0;
    logic [beq_pkg::CFG_DATA_W-1:0]    prdata;
    logic                              pready;

    // predictor state
    longint     coef_mem [N_SECT][beq_pkg::COEFS_PER_SECTION];
    longint     z1_st [N_SECT];
    longint     z2_st [N_SECT];
    logic [3:0] sect_en = 4'h0;

    eq_req_t pending_q [$];
    eq_res_t expect_q [$];
    eq_req_t cur_req;
    int      gap_cnt;
    int      rx_wait;
    int      n_results;
    int      idle_cycles;
    int      errors;
    bit      tx_gaps = 1'b1;
    bit      rx_gaps = 1'b1;

    biquad_eq_cascade u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // coef * signal, rounded to nearest with ties toward plus infinity
    function automatic longint mul_round(input longint c, input longint x);
        longint p;
        p = c * x + (longint'(1) << (FRAC - 1));
        return p >>> FRAC;
    endfunction

    function automatic longint clamp(input longint v, input int bits, inout bit hit);
        longint hi;
        longint lo;
        hi = (longint'(1) << (bits - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
        begin
            hit = 1'b1;
            return hi;
        end
        if (v < lo)
        begin
            hit = 1'b1;
            return lo;
        end
        return v;
    endfunction

    // run one accepted request through the cascade model
    task automatic filter_predict(input eq_req_t r);
        eq_res_t res;
        longint  x;
        longint  y;
        longint  z1n;
        longint  z2n;
        bit      hit;
        if (r.op == beq_pkg::OP_COEF)
        begin
            // slots past a2 are dropped, all four section codes are valid
            if (r.cidx <= beq_pkg::COEF_A2)
                coef_mem[r.sec][r.cidx] = longint'($signed(r.cval));
        end
        else
        begin
            hit = 1'b0;
            x   = longint'($signed(r.smp));
            for (int s = 0; s < N_SECT; s++)
            begin
                if (sect_en[s])
                begin
                    y   = clamp(mul_round(coef_mem[s][beq_pkg::COEF_B0], x) + z1_st[s],
                                beq_pkg::SIGNAL_BITS, hit);
                    z1n = mul_round(coef_mem[s][beq_pkg::COEF_B1], x)
                          - mul_round(coef_mem[s][beq_pkg::COEF_A1], y)
                          + z2_st[s];
                    z2n = mul_round(coef_mem[s][beq_pkg::COEF_B2], x)
                          - mul_round(coef_mem[s][beq_pkg::COEF_A2], y);
                    z1_st[s] = clamp(z1n, beq_pkg::STATE_BITS, hit);
                    z2_st[s] = clamp(z2n, beq_pkg::STATE_BITS, hit);
                    x = y;
                end
            end
            x        = clamp(x, SMP_W, hit);
            res.smp  = x[SMP_W-1:0];
            res.clip = hit;
            res.last = r.last;
            expect_q.push_back(res);
        end
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin : drive_p
        eq_req_t nxt;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            gap_cnt  <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                filter_predict(cur_req);
            if (!s_tvalid || s_tready)
            begin
                if (pending_q.size() == 0)
                    s_tvalid <= 1'b0;
                else if (gap_cnt < pending_q[0].gap)
                begin
                    gap_cnt  <= gap_cnt + 1;
                    s_tvalid <= 1'b0;
                end
                else
                begin
                    nxt      = pending_q.pop_front();
                    cur_req  <= nxt;
                    gap_cnt  <= 0;
                    s_tdata  <= {3'b000, nxt.cval, nxt.cidx, nxt.sec, nxt.smp};
                    s_tuser  <= nxt.op;
                    s_tlast  <= nxt.last;
                    s_tvalid <= 1'b1;
                end
            end
        end
    end

    // result monitor and receiver stalls
    always @(posedge clk or negedge rst_n)
    begin : watch_p
        eq_res_t want;
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            rx_wait   = 0;
            n_results = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expect_q.size() == 0)
                begin
                    $display("%0t: unexpected result: got sample %h clipped %b last %b",
                             $time, m_tdata, m_tuser, m_tlast);
                    errors++;
                end
                else
                begin
                    want = expect_q.pop_front();
                    if (m_tdata !== want.smp || m_tuser !== want.clip || m_tlast !== want.last)
                    begin
                        $display("%0t: result mismatch:", $time,
                                 " expected sample %h clipped %b last %b,",
                                 want.smp, want.clip, want.last,
                                 " got sample %h clipped %b last %b",
                                 m_tdata, m_tuser, m_tlast);
                        errors++;
                    end
                end
                n_results++;
                rx_wait = rx_gaps ? $urandom_range(0, 9) : 0;
                // long back-pressure so the block fills and stalls its input
                if (n_results == 60 || n_results == 600)
                    rx_wait = HOLD_CYCLES;
            end
            if (rx_wait != 0)
            begin
                rx_wait--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // watchdog on handshake progress
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    function automatic logic [SMP_W-1:0] rand_sample();
        if ($urandom_range(0, 9) < 7)
            return SMP_W'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
        return SMP_W'($urandom());
    endfunction

    // moderate coefficient for one slot
    function automatic logic [CV_W-1:0] rand_coef(input logic [IDX_W-1:0] idx);
        longint lim;
        longint v;
        case (idx)
            beq_pkg::COEF_A1: lim = (COEF_ONE * 9) / 5;
            beq_pkg::COEF_A2: lim = (COEF_ONE * 9) / 10;
            default:          lim = (COEF_ONE * 3) / 2;
        endcase
        v = longint'($urandom_range(0, 32'(2 * lim))) - lim;
        return v[CV_W-1:0];
    endfunction

    task automatic push_sample(input logic [SMP_W-1:0] v, input logic lst);
        eq_req_t r;
        r.op   = beq_pkg::OP_SAMPLE;
        r.smp  = v;
        r.sec  = SEL_W'($urandom_range(0, 3));
        r.cidx = IDX_W'($urandom_range(0, 7));
        r.cval = $urandom();
        r.last = lst;
        r.gap  = tx_gaps ? $urandom_range(0, 9) : 0;
        pending_q.push_back(r);
    endtask

    task automatic push_coef(input logic [SEL_W-1:0] sec, input logic [IDX_W-1:0] idx,
                             input logic [CV_W-1:0] val);
        eq_req_t r;
        r.op   = beq_pkg::OP_COEF;
        r.smp  = SMP_W'($urandom());
        r.sec  = sec;
        r.cidx = idx;
        r.cval = val;
        r.last = 1'($urandom_range(0, 1));
        r.gap  = tx_gaps ? $urandom_range(0, 9) : 0;
        pending_q.push_back(r);
    endtask

    // stable section: |a2| < 0.9 and |a1| inside the triangle
    task automatic load_section(input logic [SEL_W-1:0] sec);
        longint a2v;
        longint a1lim;
        longint a1v;
        push_coef(sec, beq_pkg::COEF_B0, rand_coef(beq_pkg::COEF_B0));
        push_coef(sec, beq_pkg::COEF_B1, rand_coef(beq_pkg::COEF_B1));
        push_coef(sec, beq_pkg::COEF_B2, rand_coef(beq_pkg::COEF_B2));
        a2v   = longint'($signed(rand_coef(beq_pkg::COEF_A2)));
        a1lim = ((COEF_ONE + a2v) * 15) / 16;
        a1v   = longint'($urandom_range(0, 32'(2 * a1lim))) - a1lim;
        push_coef(sec, beq_pkg::COEF_A1, a1v[CV_W-1:0]);
        push_coef(sec, beq_pkg::COEF_A2, a2v[CV_W-1:0]);
    endtask

    // everything sent, answered and settled
    task automatic wait_idle();
        while (pending_q.size() != 0 || s_tvalid || expect_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic cfg_write(input logic [3:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ENABLE_ADDR;
        pwdata  <= {28'd0, val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sect_en = val;
        @(negedge clk);
    endtask

    // one random phase: new enables, fresh filters, mixed traffic
    task automatic run_phase(input logic [3:0] en, input bit txg, input bit rxg);
        int roll;
        wait_idle();
        cfg_write(en);
        tx_gaps = txg;
        rx_gaps = rxg;
        for (int s = 0; s < N_SECT; s++)
            if ($urandom_range(0, 3) != 0)
                load_section(s[SEL_W-1:0]);
        repeat (PHASE_ITEMS)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 84)
                push_sample(rand_sample(), $urandom_range(0, 3) == 0);
            else if (roll < 94)
            begin
                roll = $urandom_range(0, 4);
                push_coef(SEL_W'($urandom_range(0, 3)), roll[IDX_W-1:0],
                          rand_coef(roll[IDX_W-1:0]));
            end
            else
                push_coef(SEL_W'($urandom_range(0, 3)), IDX_W'($urandom_range(0, 7)),
                          $urandom());
        end
    endtask

    initial
    begin
        logic [3:0] en_plan [PHASES];
        logic [3:0] en;
        en_plan = '{4'hF, 4'h0, 4'h1, 4'h6, 4'hF, 4'h0, 4'h8, 4'h3, 4'hF, 4'hB};
        errors  = 0;
        for (int s = 0; s < N_SECT; s++)
        begin
            for (int k = 0; k < beq_pkg::COEFS_PER_SECTION; k++)
                coef_mem[s][k] = 0;
            coef_mem[s][beq_pkg::COEF_B0] = COEF_ONE;
            z1_st[s] = 0;
            z2_st[s] = 0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // bypassed cascade passes the extremes straight through
        push_sample(24'h7FFFFF, 1'b0);
        push_sample(24'h800000, 1'b1);
        push_sample(24'h000000, 1'b0);
        push_sample(24'hFFFFFF, 1'b1);
        // writes to slots past a2 must be dropped
        push_coef(2'd0, 3'd7, 32'h7FFFFFFF);
        push_coef(2'd3, 3'd5, 32'h80000000);
        wait_idle();
        cfg_write(4'hF);
        // unity sections
        push_sample(24'h7FFFFF, 1'b0);
        push_sample(24'h800000, 1'b1);
        // huge gain and feedback drive output and states into saturation
        push_coef(2'd0, beq_pkg::COEF_B0, 32'h7FFFFFFF);
        push_coef(2'd1, beq_pkg::COEF_A1, 32'h80000000);
        push_coef(2'd1, beq_pkg::COEF_A2, 32'h7FFFFFFF);
        push_sample(24'h7FFFFF, 1'b0);
        push_sample(24'h800000, 1'b0);
        push_sample(24'h7FFFFF, 1'b0);
        push_sample(24'h800000, 1'b0);
        push_sample(24'h7FFFFF, 1'b1);
        // new coefficients apply from the next sample, states are kept
        push_coef(2'd1, beq_pkg::COEF_A1, 32'h00000000);
        push_coef(2'd1, beq_pkg::COEF_A2, 32'h00000000);
        push_coef(2'd0, beq_pkg::COEF_B0, COEF_ONE[CV_W-1:0]);
        push_sample(24'h003039, 1'b0);
        push_coef(2'd2, beq_pkg::COEF_B2, -COEF_ONE[CV_W-1:0]);
        push_sample(24'hFFCFC7, 1'b1);

        for (int p = 0; p < PHASES; p++)
        begin
            en = en_plan[p];
            if (p == 7)
                en = 4'($urandom_range(0, 15));
            run_phase(en, (p % 3) != 1, (p % 4) != 1);
        end

        wait_idle();
        if (expect_q.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, expect_q.size());
            errors++;
        end
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[filelist.f]
+incdir+src
src/beq_pkg.sv
src/beq_ram.sv
src/beq_ctrl.sv
src/beq_datapath.sv
src/biquad_eq_cascade.sv
src/beq_checker.sv
dv/tb_top.sv
